>>> hdl/alt_pkg.sv
// Shared types and codes for the array list table.
// Holds the request and response transactions, the cell command and the FSM states.
// No dependencies.
package alt_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_ILLEGAL  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] found_position;
      logic [4:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      CA_HOLD    = 3'd0,
      CA_INSERT  = 3'd1,
      CA_DELETE  = 3'd2,
      CA_COMPARE = 3'd3,
      CA_SHIFT   = 3'd4
   } cell_action_type;

   typedef struct packed {
      cell_action_type action;
      logic [31:0]     value;
      logic [4:0]      position;
   } cell_cmd_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

endpackage

>>> hdl/alt_cell.sv
// One storage cell of the array list table: one entry and one match flag.
// Entries from both sides, match flag from the right. Depends on alt_pkg.
module alt_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alt_pkg::cell_cmd_type cmd,
   input  logic [CNT_W-1:0]      count,
   input  logic [31:0]           left_entry,
   input  logic [31:0]           right_entry,
   input  logic                  right_match,
   output logic [31:0]           entry,
   output logic                  match
);

   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic [31:0]      entry_ff;
   logic [31:0]      entry_in;
   logic             match_ff;
   logic             match_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;

   assign pos_ext = CMP_W'(cmd.position);
   assign cnt_ext = CMP_W'(count);

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      unique case (cmd.action)
         alt_pkg::CA_INSERT: begin
            // take the left neighbor above the slot, the new value at it
            if (IDX > pos_ext) begin
               entry_in = left_entry;
            end else if (IDX == pos_ext) begin
               entry_in = cmd.value;
            end
         end
         alt_pkg::CA_DELETE: begin
            if (IDX >= pos_ext) begin
               entry_in = right_entry;
            end
         end
         alt_pkg::CA_COMPARE: begin
            // only live entries may match
            match_in = (entry_ff == cmd.value) && (IDX < cnt_ext);
         end
         alt_pkg::CA_SHIFT: begin
            match_in = right_match;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

>>> hdl/array_list_table.sv
// Top level of the array list table: a row of alt_cell storage cells and the
// request FSM. Depends on alt_pkg and alt_cell.
//
// Usage:
//   A request transaction (req_data: op, value, position) is taken on a rising
//   edge where start is high and busy is low. Every request gives exactly one
//   response transaction on rsp_data, shown for one cycle with rsp_valid high.
//   The receiver cannot stall; it must sample rsp_data whenever rsp_valid is high.
// Throughput and find scan:
//   Insert, delete and the unused op answer in the cycle after acceptance and
//   keep busy low, so one of them can be taken every cycle while no find scan
//   runs. Every cell moves its entry to its neighbor in the same cycle, which
//   sets that figure. Find compares all cells in parallel in the accept cycle,
//   then shifts the match flags down the row one cell per cycle and watches
//   cell 0; busy is high during the scan. On an empty list find answers in the
//   cycle after acceptance. The flag shift sets how long a find scan lasts.
// Reset:
//   Synchronous, active high. The list is empty afterwards; entries stay
//   undefined until written and are never read before that.
module array_list_table #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  alt_pkg::req_type req_data,
   output logic             rsp_valid,
   output alt_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   alt_pkg::state_type    state_ff;
   alt_pkg::state_type    state_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [IDX_W-1:0]      scan_idx_ff;
   logic [IDX_W-1:0]      scan_idx_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   alt_pkg::rsp_type      rsp_ff;
   alt_pkg::rsp_type      rsp_in;
   alt_pkg::cell_cmd_type cell_cmd;

   logic                  accept;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      idx_ext;
   logic [CMP_W-1:0]      cnt_out;

   logic [31:0]           entry_w [CAPACITY];
   logic [CAPACITY-1:0]   match_w;

   assign busy    = (state_ff == alt_pkg::S_SCAN);
   assign accept  = start && !busy;
   assign pos_ext = CMP_W'(req_data.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign idx_ext = CMP_W'(scan_idx_ff);
   assign cnt_out = CMP_W'(count_in);

   // Row of cells: each takes its left neighbor on insert, its right on delete,
   // and its right neighbor's match flag during a scan.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] left_w;
      logic [31:0] right_w;
      logic        right_match_w;

      if (i == 0) begin : g_first
         assign left_w = req_data.value;
      end else begin : g_mid_l
         assign left_w = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w       = '0;
         assign right_match_w = 1'b0;
      end else begin : g_mid_r
         assign right_w       = entry_w[i+1];
         assign right_match_w = match_w[i+1];
      end

      alt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .count       (count_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .right_match (right_match_w),
         .entry       (entry_w[i]),
         .match       (match_w[i])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alt_pkg::S_IDLE: begin
            if (accept && (req_data.op == alt_pkg::OP_FIND) && (count_ff != '0)) begin
               state_in = alt_pkg::S_SCAN;
            end
         end
         alt_pkg::S_SCAN: begin
            if (match_w[0] || ((idx_ext + CMP_W'(1)) == cnt_ext)) begin
               state_in = alt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = alt_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs: cell command, count, scan index and the response
   always_comb begin
      cell_cmd.action   = alt_pkg::CA_HOLD;
      cell_cmd.value    = req_data.value;
      cell_cmd.position = req_data.position;
      count_in          = count_ff;
      scan_idx_in       = scan_idx_ff;
      rsp_valid_in      = 1'b0;
      rsp_in.status     = alt_pkg::ST_OK;
      rsp_in.found_position = '0;
      unique case (state_ff)
         alt_pkg::S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_data.op)
                  alt_pkg::OP_INSERT: begin
                     // fullness is checked before the position
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_in.status = alt_pkg::ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        rsp_in.status = alt_pkg::ST_ILLEGAL;
                     end else begin
                        cell_cmd.action = alt_pkg::CA_INSERT;
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  alt_pkg::OP_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_in.status = alt_pkg::ST_EMPTY;
                     end else begin
                        cell_cmd.action = alt_pkg::CA_DELETE;
                        count_in        = count_ff - CNT_W'(1);
                     end
                  end
                  alt_pkg::OP_FIND: begin
                     // empty list: answer at once, otherwise start the scan
                     if (count_ff == '0) begin
                        rsp_in.status = alt_pkg::ST_NOTFOUND;
                     end else begin
                        rsp_valid_in    = 1'b0;
                        cell_cmd.action = alt_pkg::CA_COMPARE;
                        scan_idx_in     = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         alt_pkg::S_SCAN: begin
            if (match_w[0]) begin
               rsp_valid_in          = 1'b1;
               rsp_in.found_position = idx_ext[3:0];
            end else if ((idx_ext + CMP_W'(1)) == cnt_ext) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = alt_pkg::ST_NOTFOUND;
            end else begin
               cell_cmd.action = alt_pkg::CA_SHIFT;
               scan_idx_in     = scan_idx_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_in.entry_count = cnt_out[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alt_pkg::S_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload; only the strobe needs reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Count never goes beyond the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // Any accepted request other than find answers in the next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op != alt_pkg::OP_FIND)) |=> rsp_valid)
      else $error("missing response for a non-find request");

   // A response always lands back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == alt_pkg::S_IDLE))
      else $error("response while scan still running");

   // Count moves only after an accepted request
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a request");

   // The scan never walks past the live entries
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == alt_pkg::S_SCAN) |-> (idx_ext < cnt_ext))
      else $error("scan index beyond entry count");

endmodule

>>> test/tb_array_list_table.sv
// Self-checking testbench for array_list_table: directed and random insert, delete
// and find transactions, checked against a behavioral list kept in a scoreboard class.
// Depends on alt_pkg and the array_list_table RTL.
`timescale 1ns / 100ps

module tb_array_list_table;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 800;
   // A find scan is bounded by the entry count, so this covers any
   // response still in flight once the answer queue has run dry.
   localparam int DRAIN_CYCLES = CAPACITY + 4;
   // The longest quiet stretch in a correct run is the longest idle_gap or a
   // full find scan, so allow many times the larger.
   localparam int IDLE_LIMIT   = 2000;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   logic             busy;
   alt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   alt_pkg::rsp_type rsp_data;

   // Behavioral copy of the list plus the queue of answers still owed by the block.
   class list_scoreboard;
      logic [31:0]      entries [CAPACITY];
      int               count;
      alt_pkg::rsp_type answers [$];
      int               errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // Apply one accepted request to the list and queue the answer it must give.
      function void note_request(alt_pkg::req_type r);
         alt_pkg::rsp_type ans;
         int               pos;
         int               i;
         bit               hit;
         ans.status         = alt_pkg::ST_OK;
         ans.found_position = '0;
         pos                = int'(r.position);
         hit                = 1'b0;
         case (r.op)
            alt_pkg::OP_INSERT: begin
               // fullness wins over a bad position
               if (count >= CAPACITY) begin
                  ans.status = alt_pkg::ST_FULL;
               end else if (pos > count) begin
                  ans.status = alt_pkg::ST_ILLEGAL;
               end else begin
                  for (i = count; i > pos; i--) entries[i] = entries[i - 1];
                  entries[pos] = r.value;
                  count++;
               end
            end
            alt_pkg::OP_DELETE: begin
               if (pos >= count) begin
                  ans.status = alt_pkg::ST_EMPTY;
               end else begin
                  for (i = pos; i + 1 < count; i++) entries[i] = entries[i + 1];
                  count--;
               end
            end
            alt_pkg::OP_FIND: begin
               // lowest matching position only; unwritten cells lie at or above count
               for (i = 0; i < count; i++) begin
                  if (!hit && entries[i] == r.value) begin
                     ans.found_position = i[3:0];
                     hit                = 1'b1;
                  end
               end
               if (!hit) ans.status = alt_pkg::ST_NOTFOUND;
            end
            default: ;
         endcase
         ans.entry_count = count[4:0];
         answers.push_back(ans);
      endfunction

      // Compare one response transaction with the oldest queued answer.
      task check_answer(alt_pkg::rsp_type got);
         alt_pkg::rsp_type want;
         if (answers.size() == 0) begin
            report($sformatf("response with nothing queued: status %0d pos %0d count %0d",
                             got.status, got.found_position, got.entry_count));
            return;
         end
         want = answers.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.found_position !== want.found_position)
            report($sformatf("found_position got %0d want %0d",
                             got.found_position, want.found_position));
         if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d",
                             got.entry_count, want.entry_count));
      endtask
   endclass

   list_scoreboard sb = new();

   logic [31:0] value_pool [8];
   bit          gaps_on = 1'b1;
   int          idle_cycles = 0;

   array_list_table #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Present one request and hold it until an edge with busy low takes it. The
   // scoreboard is updated here, in the driver's own process, so the next pick
   // sees the list exactly as the block holds it.
   task automatic send_request(input alt_pkg::op_type op, input logic [31:0] value,
                               input logic [4:0] position);
      alt_pkg::req_type r;
      r.op       = op;
      r.value    = value;
      r.position = position;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   // Drop start for a random gap: mostly none or short, now and then long.
   task automatic idle_gap();
      int n;
      if (!gaps_on || $urandom_range(0, 99) < 55) return;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(8, 40);
      else n = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Favor a small pool of values so finds hit and duplicates pile up.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Weight the request kind by phase: filling drives the list to full, draining to empty.
   function automatic alt_pkg::op_type pick_op(bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return alt_pkg::OP_UNUSED;
      if (roll < 25) return alt_pkg::OP_FIND;
      if (filling) return (roll < 82) ? alt_pkg::OP_INSERT : alt_pkg::OP_DELETE;
      return (roll < 45) ? alt_pkg::OP_INSERT : alt_pkg::OP_DELETE;
   endfunction

   function automatic logic [4:0] pick_position(alt_pkg::op_type op);
      int roll;
      roll = $urandom_range(0, 99);
      if (op == alt_pkg::OP_INSERT) begin
         if (roll < 70) return 5'($urandom_range(0, sb.count));
         if (roll < 85) return 5'(sb.count);
      end else if (op == alt_pkg::OP_DELETE && sb.count > 0 && roll < 80) begin
         return 5'($urandom_range(0, sb.count - 1));
      end
      return 5'($urandom_range(0, 31));
   endfunction

   // Stimulus: reset, directed corner cases, then phased random traffic.
   initial begin
      alt_pkg::op_type op;
      bit              filling;
      int              phase_left;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int k = 4; k < 8; k++) value_pool[k] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: find misses, delete has nothing, insert past the end is illegal
      send_request(alt_pkg::OP_FIND,   32'h0000_0000, 5'd0);
      send_request(alt_pkg::OP_DELETE, 32'h0000_0000, 5'd0);
      idle_gap();
      send_request(alt_pkg::OP_INSERT, 32'h0000_0005, 5'd1);
      send_request(alt_pkg::OP_INSERT, 32'h0000_0005, 5'd31);
      send_request(alt_pkg::OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
      // build 0, min, max, max: extremes of the value and a duplicate
      send_request(alt_pkg::OP_INSERT, 32'h8000_0000, 5'd0);
      send_request(alt_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1);
      idle_gap();
      send_request(alt_pkg::OP_INSERT, 32'h0000_0000, 5'd0);
      send_request(alt_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd3);
      // lowest of two matches, position 1, position 0 and a miss
      send_request(alt_pkg::OP_FIND,   32'h7FFF_FFFF, 5'd0);
      send_request(alt_pkg::OP_FIND,   32'h8000_0000, 5'd31);
      send_request(alt_pkg::OP_FIND,   32'h0000_0000, 5'd0);
      send_request(alt_pkg::OP_FIND,   32'hFFFF_FFFF, 5'd0);
      idle_gap();
      // delete at and beyond the count, append at the count, remove last and first
      send_request(alt_pkg::OP_DELETE, 32'h0000_0000, 5'd31);
      send_request(alt_pkg::OP_DELETE, 32'h0000_0000, 5'd4);
      send_request(alt_pkg::OP_INSERT, 32'h0000_0011, 5'd4);
      send_request(alt_pkg::OP_DELETE, 32'h0000_0000, 5'd4);
      send_request(alt_pkg::OP_DELETE, 32'hFFFF_FFFF, 5'd0);
      send_request(alt_pkg::OP_UNUSED, 32'h0000_0000, 5'd0);
      send_request(alt_pkg::OP_FIND,   32'h7FFF_FFFF, 5'd0);

      filling    = 1'b1;
      phase_left = $urandom_range(40, 120);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // switch between gappy and back-to-back stretches
         if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(40, 120);
         end
         phase_left--;
         idle_gap();
         op = pick_op(filling);
         send_request(op, pick_value(), pick_position(op));
      end
      start <= 1'b0;

      // wait out every owed answer, then a margin for strays
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Check every response transaction in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_answer(rsp_data);
   end

   // Watchdog: end the run if nothing is accepted on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
